// ===== hw/rtl/pmt_pkg.sv =====
// Shared types and constants of the program map section parser.
package pmt_pkg;

	localparam int unsigned POS_W = 13;
	localparam int unsigned COUNT_W = 10;

	localparam logic [POS_W-1:0] MAX_SECTION_BYTES = 13'd4096;
	localparam logic [POS_W-1:0] HEADER_BYTES = 13'd12;
	localparam logic [POS_W-1:0] CRC_BYTES = 13'd4;
	localparam logic [POS_W-1:0] LENGTH_BIAS = 13'd3;
	localparam logic [POS_W-1:0] MIN_FULL_BYTES = 13'd16;
	localparam logic [POS_W-1:0] SIZE_POS = 13'd2;
	localparam logic [POS_W-1:0] POS_MAX = 13'd8191;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

	// Header byte positions.
	localparam logic [3:0] POS_LEN_HI = 4'd1;
	localparam logic [3:0] POS_LEN_LO = 4'd2;
	localparam logic [3:0] POS_PROG_HI = 4'd3;
	localparam logic [3:0] POS_PROG_LO = 4'd4;
	localparam logic [3:0] POS_SECNUM = 4'd6;
	localparam logic [3:0] POS_LASTNUM = 4'd7;
	localparam logic [3:0] POS_PCR_HI = 4'd8;
	localparam logic [3:0] POS_PCR_LO = 4'd9;
	localparam logic [3:0] POS_INFO_HI = 4'd10;
	localparam logic [3:0] POS_INFO_LO = 4'd11;

	// Byte index within an elementary stream entry.
	localparam logic [2:0] EIDX_TYPE = 3'd0;
	localparam logic [2:0] EIDX_PID_HI = 3'd1;
	localparam logic [2:0] EIDX_PID_LO = 3'd2;
	localparam logic [2:0] EIDX_ESL_HI = 3'd3;
	localparam logic [2:0] EIDX_ESL_LO = 3'd4;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = 2;
	localparam int unsigned FIFO_LW = 3;

	typedef struct packed {
		logic [7:0] section_byte;
		logic start_req;
	} byte_item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] stream_type;
		logic [12:0] elementary_pid;
		logic [11:0] es_info_length;
		logic [15:0] program_number;
		logic [12:0] pcr_pid;
		logic [7:0] section_number;
		logic [7:0] last_section_number;
		logic [COUNT_W-1:0] entry_count;
		logic truncated;
		logic last;
	} result_t;

	typedef struct packed {
		logic room;
		logic [FIFO_LW-1:0] level;
	} fifo_stat_t;

endpackage

// ===== hw/rtl/pmt_if.sv =====
// Channel interfaces: section bytes in, parse results out.
interface pmt_byte_if;
	logic valid;
	logic ready;
	logic [7:0] section_byte;
	logic start_req;

	modport source(output valid, output section_byte, output start_req, input ready);
	modport sink(input valid, input section_byte, input start_req, output ready);
endinterface

interface pmt_result_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] stream_type;
	logic [12:0] elementary_pid;
	logic [11:0] es_info_length;
	logic [15:0] program_number;
	logic [12:0] pcr_pid;
	logic [7:0] section_number;
	logic [7:0] last_section_number;
	logic [9:0] entry_count;
	logic truncated;
	logic last;

	modport source(output valid, output kind, output stream_type, output elementary_pid,
		output es_info_length, output program_number, output pcr_pid,
		output section_number, output last_section_number, output entry_count,
		output truncated, output last, input ready);
	modport sink(input valid, input kind, input stream_type, input elementary_pid,
		input es_info_length, input program_number, input pcr_pid,
		input section_number, input last_section_number, input entry_count,
		input truncated, input last, output ready);
endinterface

// ===== hw/rtl/pmt_section_parser_top.sv =====
// Program map section parser: section bytes in, stream entries and summaries out.
//
// The section channel carries one byte per transfer; start_req marks the table id
// byte of a new section. The result channel carries one result per transfer:
// an elementary stream entry (kind 0) when an entry's fifth byte arrives, and a
// summary (kind 1) at the section's last byte or when a new start cuts it off.
// A byte causes zero, one or two results; last marks the final one of a byte.
// A result passes through the input register and the result queue before it is
// offered. Throughput: one byte per cycle while the queue has room. Each byte
// sits in an input register, is parsed as it leaves and its results go into a
// four-entry result queue; a byte leaves the input register only when the queue
// has room for two results. While the receiver stalls, the queue absorbs up to
// four results before the input stops taking bytes; nothing is dropped.
// Reset clears the parse state and empties the queue; the block starts outside
// any section and ignores bytes until one with start_req.
module pmt_section_parser_top (
	input logic clk,
	input logic arst_n,
	pmt_byte_if.sink section,
	pmt_result_if.source result
);
	import pmt_pkg::*;

	logic valid_s1;
	byte_item_t item_s1;
	logic advance;
	logic load;
	result_t res0, res1, head;
	logic [1:0] res_count;
	fifo_stat_t fstat;

	assign advance = valid_s1 && fstat.room;
	assign section.ready = !valid_s1 || fstat.room;
	assign load = section.valid && section.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.section_byte <= section.section_byte;
			item_s1.start_req <= section.start_req;
		end
	end

	pmt_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(advance),
		.item(item_s1),
		.res0(res0),
		.res1(res1),
		.res_count(res_count)
	);

	pmt_rfifo u_rfifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_count(res_count),
		.push0(res0),
		.push1(res1),
		.pop(result.ready),
		.head(head),
		.stat(fstat)
	);

	assign result.valid = fstat.level != '0;
	assign result.kind = head.kind;
	assign result.stream_type = head.stream_type;
	assign result.elementary_pid = head.elementary_pid;
	assign result.es_info_length = head.es_info_length;
	assign result.program_number = head.program_number;
	assign result.pcr_pid = head.pcr_pid;
	assign result.section_number = head.section_number;
	assign result.last_section_number = head.last_section_number;
	assign result.entry_count = head.entry_count;
	assign result.truncated = head.truncated;
	assign result.last = head.last;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.level <= FIFO_LW'(FIFO_DEPTH))
		else $error("result queue level beyond its depth");

	a_no_push_without_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> res_count == 2'd0)
		else $error("results pushed without a parsed byte");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fstat.room |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a byte while the queue was full");

	a_entry_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_ENTRY |->
			result.program_number == 16'd0 && !result.truncated &&
			result.entry_count == '0)
		else $error("entry result carries summary fields");
`endif

endmodule

// ===== hw/rtl/pmt_parse.sv =====
// Section parse state and the per-byte result logic.
module pmt_parse (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input pmt_pkg::byte_item_t item,
	output pmt_pkg::result_t res0,
	output pmt_pkg::result_t res1,
	output logic [1:0] res_count
);
	import pmt_pkg::*;

	logic in_section_q, in_section_d;
	logic [POS_W-1:0] bp_q, bp_d;
	logic [POS_W-1:0] size_q, size_d;
	logic [15:0] prog_q, prog_d;
	logic [7:0] secn_q, secn_d;
	logic [7:0] lastn_q, lastn_d;
	logic [12:0] pcr_q, pcr_d;
	logic [11:0] info_q, info_d;
	logic [POS_W-1:0] nep_q, nep_d;
	logic [2:0] eidx_q, eidx_d;
	logic [7:0] etype_q, etype_d;
	logic [12:0] epid_q, epid_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [3:0] es_high_q, es_high_d;
	logic oversize_q, oversize_d;

	logic [7:0] b;
	logic [POS_W-1:0] p;
	logic [POS_W-1:0] sz;
	logic [POS_W-1:0] crc_start;
	logic [11:0] esl;
	logic [POS_W:0] nxt;
	logic trunc_hit, entry_hit, end_hit, end_trunc;
	result_t first_res, end_res;

	always_comb begin
		in_section_d = in_section_q;
		bp_d = bp_q;
		size_d = size_q;
		prog_d = prog_q;
		secn_d = secn_q;
		lastn_d = lastn_q;
		pcr_d = pcr_q;
		info_d = info_q;
		nep_d = nep_q;
		eidx_d = eidx_q;
		etype_d = etype_q;
		epid_d = epid_q;
		count_d = count_q;
		es_high_d = es_high_q;
		oversize_d = oversize_q;
		b = item.section_byte;
		p = '0;
		sz = '0;
		crc_start = '0;
		esl = '0;
		nxt = '0;
		trunc_hit = 1'b0;
		entry_hit = 1'b0;
		end_hit = 1'b0;
		end_trunc = 1'b0;
		first_res = '0;
		end_res = '0;

		if (item_valid) begin
			if (item.start_req) begin
				// A new start cuts off the open section with a truncated summary.
				if (in_section_q) begin
					trunc_hit = 1'b1;
					first_res.kind = KIND_SUMMARY;
					first_res.program_number = prog_q;
					first_res.pcr_pid = pcr_q;
					first_res.section_number = secn_q;
					first_res.last_section_number = lastn_q;
					first_res.entry_count = count_q;
					first_res.truncated = 1'b1;
				end
				in_section_d = 1'b1;
				bp_d = '0;
				size_d = '0;
				prog_d = '0;
				secn_d = '0;
				lastn_d = '0;
				pcr_d = '0;
				info_d = '0;
				nep_d = '0;
				eidx_d = EIDX_TYPE;
				etype_d = '0;
				epid_d = '0;
				count_d = '0;
				es_high_d = '0;
				oversize_d = 1'b0;
			end

			if (in_section_d) begin
				p = bp_d;
				if (p < HEADER_BYTES) begin
					unique case (p[3:0])
						POS_LEN_HI: size_d = {1'b0, b[3:0], 8'h00};
						POS_LEN_LO: begin
							sz = {1'b0, size_d[11:8], b} + LENGTH_BIAS;
							if (sz > MAX_SECTION_BYTES) begin
								size_d = MAX_SECTION_BYTES;
								oversize_d = 1'b1;
							end else begin
								size_d = sz;
							end
						end
						POS_PROG_HI: prog_d = {b, 8'h00};
						POS_PROG_LO: prog_d = {prog_d[15:8], b};
						POS_SECNUM: secn_d = b;
						POS_LASTNUM: lastn_d = b;
						POS_PCR_HI: pcr_d = {b[4:0], 8'h00};
						POS_PCR_LO: pcr_d = {pcr_d[12:8], b};
						POS_INFO_HI: info_d = {b[3:0], 8'h00};
						POS_INFO_LO: begin
							info_d = {info_d[11:8], b};
							nep_d = HEADER_BYTES + {1'b0, info_d};
						end
						default: ;
					endcase
				end else begin
					crc_start = (size_d >= CRC_BYTES) ? size_d - CRC_BYTES : '0;
					unique case (eidx_d)
						EIDX_TYPE: begin
							if (p == nep_d && p < crc_start) begin
								etype_d = b;
								eidx_d = EIDX_PID_HI;
							end
						end
						EIDX_PID_HI: begin
							epid_d = {b[4:0], 8'h00};
							eidx_d = EIDX_PID_LO;
						end
						EIDX_PID_LO: begin
							epid_d = {epid_d[12:8], b};
							eidx_d = EIDX_ESL_HI;
						end
						EIDX_ESL_HI: begin
							es_high_d = b[3:0];
							eidx_d = EIDX_ESL_LO;
						end
						default: begin
							esl = {es_high_d, b};
							nxt = {1'b0, p} + {{POS_W{1'b0}}, 1'b1} + {2'b00, esl};
							entry_hit = 1'b1;
							first_res.kind = KIND_ENTRY;
							first_res.stream_type = etype_d;
							first_res.elementary_pid = epid_d;
							first_res.es_info_length = esl;
							if (count_d < COUNT_MAX) begin
								count_d = count_d + 1'b1;
							end
							nep_d = (nxt > {1'b0, POS_MAX}) ? POS_MAX : nxt[POS_W-1:0];
							eidx_d = EIDX_TYPE;
						end
					endcase
				end

				bp_d = (p < POS_MAX) ? p + 1'b1 : POS_MAX;

				if (p >= SIZE_POS && ({1'b0, p} + 1'b1) == {1'b0, size_d}) begin
					end_hit = 1'b1;
					end_trunc = oversize_d || (size_d < MIN_FULL_BYTES) ||
						(eidx_d != EIDX_TYPE) || (nep_d > size_d - CRC_BYTES);
					end_res.kind = KIND_SUMMARY;
					end_res.program_number = prog_d;
					end_res.pcr_pid = pcr_d;
					end_res.section_number = secn_d;
					end_res.last_section_number = lastn_d;
					end_res.entry_count = count_d;
					end_res.truncated = end_trunc;
					in_section_d = 1'b0;
				end
			end
		end
	end

	// At most one of the cut-off summary and an entry occurs per byte.
	always_comb begin
		res0 = '0;
		res1 = '0;
		res_count = 2'd0;
		if ((trunc_hit || entry_hit) && end_hit) begin
			res0 = first_res;
			res1 = end_res;
			res1.last = 1'b1;
			res_count = 2'd2;
		end else if (trunc_hit || entry_hit) begin
			res0 = first_res;
			res0.last = 1'b1;
			res_count = 2'd1;
		end else if (end_hit) begin
			res0 = end_res;
			res0.last = 1'b1;
			res_count = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_section_q <= 1'b0;
			bp_q <= '0;
			size_q <= '0;
			prog_q <= '0;
			secn_q <= '0;
			lastn_q <= '0;
			pcr_q <= '0;
			info_q <= '0;
			nep_q <= '0;
			eidx_q <= EIDX_TYPE;
			etype_q <= '0;
			epid_q <= '0;
			count_q <= '0;
			es_high_q <= '0;
			oversize_q <= 1'b0;
		end else if (item_valid) begin
			in_section_q <= in_section_d;
			bp_q <= bp_d;
			size_q <= size_d;
			prog_q <= prog_d;
			secn_q <= secn_d;
			lastn_q <= lastn_d;
			pcr_q <= pcr_d;
			info_q <= info_d;
			nep_q <= nep_d;
			eidx_q <= eidx_d;
			etype_q <= etype_d;
			epid_q <= epid_d;
			count_q <= count_d;
			es_high_q <= es_high_d;
			oversize_q <= oversize_d;
		end
	end

endmodule

// ===== hw/rtl/pmt_rfifo.sv =====
// Small result queue that takes up to two results per cycle and gives one.
module pmt_rfifo (
	input logic clk,
	input logic arst_n,
	input logic [1:0] push_count,
	input pmt_pkg::result_t push0,
	input pmt_pkg::result_t push1,
	input logic pop,
	output pmt_pkg::result_t head,
	output pmt_pkg::fifo_stat_t stat
);
	import pmt_pkg::*;

	result_t entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_LW-1:0] level_q;
	logic [FIFO_AW-1:0] wr_next;
	logic do_pop;

	assign wr_next = wr_ptr_q + 1'b1;
	assign do_pop = pop && (level_q != '0);
	assign head = entries_q[rd_ptr_q];
	// Room is judged on the registered level so that two results always fit.
	assign stat.room = level_q <= FIFO_LW'(FIFO_DEPTH - 2);
	assign stat.level = level_q;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entries_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			entries_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + FIFO_LW'(push_count) - FIFO_LW'(do_pop);
		end
	end

endmodule

// ===== sim/tb.sv =====
// Testbench of the program map section parser: predicted results checked per transfer.
module tb;
	import pmt_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TOTAL_BYTES = 1900;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
	typedef enum int {LEN_EXACT, LEN_SHORTER, LEN_LONGER, LEN_RANDOM, LEN_FULL} length_plan_e;

	// Tracks the parse of the byte stream and holds the results it predicts.
	class section_tracker;
		result_t pending_results[$];
		int unsigned errors;

		logic in_sec;
		logic [12:0] pos;
		logic [12:0] size_r;
		logic [12:0] entry_pos;
		logic [15:0] prog;
		logic [7:0] sec_num;
		logic [7:0] last_num;
		logic [12:0] pcr;
		logic [11:0] info_len;
		logic [2:0] eidx;
		logic [7:0] etype;
		logic [12:0] epid;
		logic [3:0] esl_hi;
		logic [COUNT_W-1:0] ecount;
		logic oversize;

		function new();
			errors = 0;
			in_sec = 1'b0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			size_r = '0;
			entry_pos = '0;
			prog = '0;
			sec_num = '0;
			last_num = '0;
			pcr = '0;
			info_len = '0;
			eidx = EIDX_TYPE;
			etype = '0;
			epid = '0;
			esl_hi = '0;
			ecount = '0;
			oversize = 1'b0;
		endfunction

		function result_t summary(logic trunc);
			result_t r;
			r = '0;
			r.kind = KIND_SUMMARY;
			r.program_number = prog;
			r.pcr_pid = pcr;
			r.section_number = sec_num;
			r.last_section_number = last_num;
			r.entry_count = ecount;
			r.truncated = trunc;
			return r;
		endfunction

		function void take_byte(logic [7:0] b, logic start);
			result_t fresh[$];
			result_t r;
			logic [12:0] p;
			logic [12:0] crc_start;
			logic [13:0] sum;
			logic [11:0] esl;
			logic trunc;
			// A start inside an open section closes it as cut short.
			if (start) begin
				if (in_sec)
					fresh = {fresh, summary(1'b1)};
				clear();
				in_sec = 1'b1;
			end
			if (in_sec) begin
				p = pos;
				if (p < HEADER_BYTES) begin
					case (p[3:0])
						POS_LEN_HI: size_r = {1'b0, b[3:0], 8'h00};
						POS_LEN_LO: begin
							sum = {1'b0, size_r | {5'd0, b}} + LENGTH_BIAS;
							if (sum > MAX_SECTION_BYTES) begin
								sum = {1'b0, MAX_SECTION_BYTES};
								oversize = 1'b1;
							end
							size_r = sum[12:0];
						end
						POS_PROG_HI: prog = {b, 8'h00};
						POS_PROG_LO: prog[7:0] = b;
						POS_SECNUM: sec_num = b;
						POS_LASTNUM: last_num = b;
						POS_PCR_HI: pcr = {b[4:0], 8'h00};
						POS_PCR_LO: pcr[7:0] = b;
						POS_INFO_HI: info_len = {b[3:0], 8'h00};
						POS_INFO_LO: begin
							info_len[7:0] = b;
							entry_pos = HEADER_BYTES + {1'b0, info_len};
						end
						default: ;
					endcase
				end else begin
					crc_start = (size_r >= CRC_BYTES) ? size_r - CRC_BYTES : '0;
					case (eidx)
						EIDX_TYPE: begin
							if (p == entry_pos && p < crc_start) begin
								etype = b;
								eidx = EIDX_PID_HI;
							end
						end
						EIDX_PID_HI: begin
							epid = {b[4:0], 8'h00};
							eidx = EIDX_PID_LO;
						end
						EIDX_PID_LO: begin
							epid[7:0] = b;
							eidx = EIDX_ESL_HI;
						end
						EIDX_ESL_HI: begin
							esl_hi = b[3:0];
							eidx = EIDX_ESL_LO;
						end
						default: begin
							esl = {esl_hi, b};
							r = '0;
							r.kind = KIND_ENTRY;
							r.stream_type = etype;
							r.elementary_pid = epid;
							r.es_info_length = esl;
							fresh = {fresh, r};
							if (ecount < COUNT_MAX)
								ecount++;
							sum = {1'b0, p} + 14'd1 + {2'b00, esl};
							entry_pos = (sum > POS_MAX) ? POS_MAX : sum[12:0];
							eidx = EIDX_TYPE;
						end
					endcase
				end
				pos = (p < POS_MAX) ? p + 13'd1 : POS_MAX;
				if (p >= SIZE_POS && {1'b0, p} + 14'd1 == {1'b0, size_r}) begin
					crc_start = size_r - CRC_BYTES;
					trunc = oversize || size_r < MIN_FULL_BYTES || eidx != EIDX_TYPE ||
						entry_pos > crc_start;
					fresh = {fresh, summary(trunc)};
					in_sec = 1'b0;
				end
			end
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last = 1'b1;
			pending_results = {pending_results, fresh};
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with none expected", $time, got);
				return;
			end
			want = pending_results.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("stream_type", want.stream_type, got.stream_type);
			check_field("elementary_pid", want.elementary_pid, got.elementary_pid);
			check_field("es_info_length", want.es_info_length, got.es_info_length);
			check_field("program_number", want.program_number, got.program_number);
			check_field("pcr_pid", want.pcr_pid, got.pcr_pid);
			check_field("section_number", want.section_number, got.section_number);
			check_field("last_section_number", want.last_section_number,
				got.last_section_number);
			check_field("entry_count", want.entry_count, got.entry_count);
			check_field("truncated", want.truncated, got.truncated);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pmt_byte_if section();
	pmt_result_if result();

	pmt_section_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.section(section),
		.result(result)
	);

	section_tracker tracker;
	int gap_max = 0;
	int burst_left = 0;
	int sent_bytes = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int unsigned phase_cnt = 0;
	logic [15:0] stall_mask = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] field_byte(fill_e fill);
		case (fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// The sender runs in bursts; valid is only lowered when a gap follows.
	task automatic send_byte(input logic [7:0] value, input logic first);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				section.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		section.valid <= 1'b1;
		section.section_byte <= value;
		section.start_req <= first;
		do @(posedge clk); while (!section.ready);
		tracker.take_byte(value, first);
		sent_bytes++;
	endtask

	task automatic send_section(input fill_e hdr_fill, input fill_e ent_fill,
		input int info_len, input int n_ent, input int desc_max, input bit esl_lie,
		input length_plan_e plan, input int delta, input int cut, input int trailing);
		logic [7:0] body[$];
		logic [7:0] bytes_out[$];
		logic [7:0] r;
		logic [11:0] esl;
		logic [11:0] len_field;
		logic [11:0] info_field;
		int length_value;
		int desc;
		info_field = info_len[11:0];
		for (int i = 0; i < info_len && i < 8; i++)
			body = {body, field_byte(hdr_fill)};
		for (int e = 0; e < n_ent; e++) begin
			desc = $urandom_range(0, desc_max);
			if (!esl_lie)
				esl = desc[11:0];
			else if (ent_fill == FILL_ZERO)
				esl = '0;
			else if (ent_fill == FILL_ONES)
				esl = 12'hFFF;
			else
				esl = 12'($urandom_range(0, 4095));
			body = {body, field_byte(ent_fill)};
			body = {body, field_byte(ent_fill)};
			body = {body, field_byte(ent_fill)};
			r = field_byte(ent_fill);
			r = {r[7:4], esl[11:8]};
			body = {body, r};
			body = {body, esl[7:0]};
			repeat (desc) body = {body, field_byte(FILL_RANDOM)};
		end
		repeat (4) body = {body, field_byte(FILL_RANDOM)};
		length_value = 12 + body.size() - 3;
		case (plan)
			LEN_SHORTER: length_value = (length_value > delta) ? length_value - delta : 0;
			LEN_LONGER: length_value = (length_value + delta > 4095) ? 4095 : length_value + delta;
			LEN_RANDOM: length_value = $urandom_range(0, 4095);
			LEN_FULL: begin
				length_value = 4095;
				while (12 + body.size() < 4096)
					body = {body, field_byte(hdr_fill)};
			end
			default: ;
		endcase
		len_field = length_value[11:0];
		bytes_out = {bytes_out, field_byte(hdr_fill)};
		r = field_byte(hdr_fill);
		r = {r[7:4], len_field[11:8]};
		bytes_out = {bytes_out, r};
		bytes_out = {bytes_out, len_field[7:0]};
		// Program number, version, section numbers and PCR PID.
		repeat (7) bytes_out = {bytes_out, field_byte(hdr_fill)};
		r = field_byte(hdr_fill);
		r = {r[7:4], info_field[11:8]};
		bytes_out = {bytes_out, r};
		bytes_out = {bytes_out, info_field[7:0]};
		bytes_out = {bytes_out, body};
		if (cut > 0 && cut < bytes_out.size())
			bytes_out = bytes_out[0:cut - 1];
		else
			repeat (trailing) bytes_out = {bytes_out, field_byte(FILL_RANDOM)};
		foreach (bytes_out[i])
			send_byte(bytes_out[i], i == 0);
	endtask

	// Receiver: checks each result transfer and stalls on a rotating pattern.
	always @(posedge clk) begin : receiver
		result_t got;
		if (arst_n && result.valid && result.ready) begin
			got.kind = result.kind;
			got.stream_type = result.stream_type;
			got.elementary_pid = result.elementary_pid;
			got.es_info_length = result.es_info_length;
			got.program_number = result.program_number;
			got.pcr_pid = result.pcr_pid;
			got.section_number = result.section_number;
			got.last_section_number = result.last_section_number;
			got.entry_count = result.entry_count;
			got.truncated = result.truncated;
			got.last = result.last;
			tracker.match_result(got);
		end
		phase_cnt++;
		if (phase_cnt % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_mask = '0;
				1: stall_mask = 16'($urandom);
				2: stall_mask = 16'($urandom | $urandom);
				default: stall_mask = 16'($urandom & $urandom);
			endcase
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= !stall_mask[phase_cnt[3:0]];
		end
	end

	always @(posedge clk) begin
		if ((section.valid && section.ready) || (result.valid && result.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		length_plan_e plan;
		int roll;
		tracker = new();
		arst_n = 1'b0;
		section.valid = 1'b0;
		section.section_byte = '0;
		section.start_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_max = 3;
		// Bytes before any start are dropped.
		repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_section(FILL_ZERO, FILL_ZERO, 0, 0, 0, 0, LEN_EXACT, 0, 0, 0);
		send_section(FILL_ONES, FILL_ONES, 0, 2, 2, 0, LEN_EXACT, 0, 0, 2);
		send_section(FILL_RANDOM, FILL_ONES, 0, 1, 0, 1, LEN_EXACT, 0, 0, 0);
		send_section(FILL_RANDOM, FILL_ZERO, 0, 1, 0, 1, LEN_EXACT, 0, 0, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 0, 0, 0, LEN_SHORTER, 100, 0, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 0, 0, 0, LEN_SHORTER, 3, 0, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 2, 1, 0, LEN_EXACT, 0, 1, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 2, 1, 0, LEN_EXACT, 0, 2, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 2, 3, 1, 0, LEN_EXACT, 0, 19, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 3, 0, 0, LEN_SHORTER, 2, 0, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 3, 0, 0, LEN_SHORTER, 5, 0, 0);
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 2, 1, 0, LEN_LONGER, 2, 0, 3);
		send_section(FILL_RANDOM, FILL_RANDOM, 100, 1, 1, 0, LEN_EXACT, 0, 0, 0);

		// Long receiver hold while a section full of entries keeps coming.
		gap_max = 0;
		hold_req <= hold_req + 1;
		send_section(FILL_RANDOM, FILL_RANDOM, 0, 40, 0, 0, LEN_EXACT, 0, 0, 0);

		while (sent_bytes < TOTAL_BYTES) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				send_section(FILL_RANDOM, FILL_RANDOM,
					($urandom_range(0, 19) == 0) ? $urandom_range(9, 4095) :
						$urandom_range(0, 4),
					$urandom_range(0, 6), $urandom_range(0, 4), 0, LEN_EXACT, 0, 0,
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			end else if (roll < 80) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				case ($urandom_range(0, 3))
					0: plan = LEN_SHORTER;
					1: plan = LEN_LONGER;
					2: plan = LEN_RANDOM;
					default: plan = LEN_EXACT;
				endcase
				send_section(FILL_RANDOM, FILL_RANDOM, $urandom_range(0, 4),
					$urandom_range(0, 5), $urandom_range(0, 3), $urandom_range(0, 1),
					plan, $urandom_range(1, 8),
					$urandom_range(0, 1) ? $urandom_range(1, 40) : 0,
					$urandom_range(0, 8));
			end
		end

		section.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== pmt_section_parser_top.f =====
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_if.sv
hw/rtl/pmt_parse.sv
hw/rtl/pmt_rfifo.sv
hw/rtl/pmt_section_parser_top.sv
sim/tb.sv
